// ===== hw/rtl/wed_pkg.sv =====
// ============================================================================
// wed_pkg
// Shared types, constants and helper functions for the windowed extremum
// detector.
// ============================================================================
package wed_pkg;

  localparam int MAX_RADIUS  = 18;
  localparam int MAX_SAMPLES = 4096;

  localparam int VAL_W      = 28;
  localparam int IDX_W      = 12;
  localparam int RAD_W      = 5;
  localparam int PROM_W     = 28;
  localparam int TOL_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_RADIUS  = 2'd0,
    CFG_MIN_PROMINENCE = 2'd1,
    CFG_WANT_MAXIMUM   = 2'd2,
    CFG_TIE_TOLERANCE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RAD_W-1:0]  window_radius;
    logic [PROM_W-1:0] min_prominence;
    logic              want_maximum;
    logic [TOL_W-1:0]  tie_tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_radius:  RAD_W'(5),
    min_prominence: PROM_W'(3277),
    want_maximum:   1'b1,
    tie_tolerance:  TOL_W'(4)
  };

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic signed [VAL_W-1:0] along_pos;
    logic                    last_sample;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        center_index;
    logic signed [VAL_W-1:0] center_along;
    logic [PROM_W-1:0]       peak_prominence;
  } out_t;

  // Context that leaves the window stage with each sample.
  typedef struct packed {
    logic             test;
    logic [IDX_W-1:0] idx;
  } win_ctx_t;

  // Candidate centre carried alongside the reduction tree.
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    val_t             centre;
    val_t             along;
  } cand_t;

  // Largest key; excluded neighbours take it so they never win a minimum.
  localparam val_t KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  function automatic val_t key_min(val_t a, val_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic val_t key_min4(val_t a, val_t b, val_t c, val_t d);
    return key_min(key_min(a, b), key_min(c, d));
  endfunction

  // Entries left after a number of four-to-one reduction levels.
  function automatic int level_count(int n, int lvl);
    int c;
    int j;
    c = n;
    for (j = 0; j < lvl; j++) begin
      c = (c + 3) >> 2;
    end
    return c;
  endfunction

  // Four-to-one levels needed to bring n entries down to one.
  function automatic int tree_levels(int n);
    int c;
    int l;
    c = n;
    l = 0;
    while (c > 1) begin
      c = (c + 3) >> 2;
      l++;
    end
    return l;
  endfunction

endpackage

// ===== hw/rtl/wed_window.sv =====
// ============================================================================
// wed_window
// Sample window shift register and per-profile sample counter.
// ============================================================================
module wed_window #(
  parameter int MaxRadius  = wed_pkg::MAX_RADIUS,
  parameter int MaxSamples = wed_pkg::MAX_SAMPLES,
  localparam int N  = 2 * MaxRadius + 1,
  localparam int RW = $clog2(MaxRadius + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wed_pkg::in_t       in_data_i,
  input  logic [RW-1:0]      rad_i,
  input  logic               adv_i,
  output logic               win_v_o,
  output wed_pkg::win_ctx_t  ctx_o,
  output wed_pkg::val_t      val_o [N],
  output wed_pkg::val_t      pos_o [N]
);

  localparam int CW = $clog2(MaxSamples);

  wed_pkg::val_t     val_q [N];
  wed_pkg::val_t     pos_q [N];
  logic [CW-1:0]     count_q, count_d;
  logic              v_q;
  wed_pkg::win_ctx_t ctx_q, ctx_d;
  logic              acc;

  // The window is the input register: it may only shift once its previous
  // contents have moved on to the test stage.
  assign in_stall_o = v_q && !adv_i;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    ctx_d.test = int'(count_q) >= 2 * int'(rad_i);
    ctx_d.idx  = wed_pkg::IDX_W'(count_q - CW'(rad_i));
    if (in_data_i.last_sample) begin
      count_d = '0;
    end else if (count_q != CW'(MaxSamples - 1)) begin
      count_d = count_q + CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      count_q <= '0;
    end else if (acc) begin
      v_q     <= 1'b1;
      count_q <= count_d;
    end else if (adv_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      val_q[0] <= in_data_i.sample_value;
      pos_q[0] <= in_data_i.along_pos;
      for (int k = 1; k < N; k++) begin
        val_q[k] <= val_q[k-1];
        pos_q[k] <= pos_q[k-1];
      end
      ctx_q <= ctx_d;
    end
  end

  assign win_v_o = v_q;
  assign ctx_o   = ctx_q;
  assign val_o   = val_q;
  assign pos_o   = pos_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxSamples - 1))
    else $error("sample counter beyond its saturation value");

  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.last_sample) |=> (count_q == '0))
    else $error("sample counter not restarted after the last sample");

endmodule

// ===== hw/rtl/wed_test.sv =====
// ============================================================================
// wed_test
// Centre selection, tolerance test and neighbour key generation.
// ============================================================================
module wed_test #(
  parameter int MaxRadius = wed_pkg::MAX_RADIUS,
  localparam int N  = 2 * MaxRadius + 1,
  localparam int RW = $clog2(MaxRadius + 1),
  localparam int IW = $clog2(N)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wed_pkg::cfg_t      cfg_i,
  input  logic [RW-1:0]      rad_i,
  input  logic               win_v_i,
  input  wed_pkg::win_ctx_t  win_ctx_i,
  input  wed_pkg::val_t      val_i [N],
  input  wed_pkg::val_t      pos_i [N],
  output logic               free_o,
  input  logic               adv_i,
  output logic               v_o,
  output wed_pkg::cand_t     cand_o,
  output wed_pkg::val_t      key_o [N]
);

  localparam int W1 = wed_pkg::VAL_W + 1;

  logic           v_q;
  logic           ld;
  wed_pkg::cand_t cand_q, cand_d;
  wed_pkg::val_t  key_q [N];
  wed_pkg::val_t  key_d [N];

  assign ld     = !v_q || adv_i;
  assign free_o = ld;

  // In minimum mode the keys are inverted, so the tree always looks for a
  // minimum; inversion keeps the order reversed without any overflow.
  always_comb begin
    wed_pkg::val_t      centre;
    logic signed [W1-1:0] c_ext;
    logic signed [W1-1:0] t_ext;
    logic signed [W1-1:0] n_ext;
    logic                 use_k;
    logic                 viol;
    centre = val_i[IW'(rad_i)];
    c_ext  = {centre[wed_pkg::VAL_W-1], centre};
    t_ext  = $signed(W1'(cfg_i.tie_tolerance));
    viol   = 1'b0;
    for (int k = 0; k < N; k++) begin
      use_k = (k != int'(rad_i)) && (k <= 2 * int'(rad_i));
      n_ext = {val_i[k][wed_pkg::VAL_W-1], val_i[k]};
      if (!use_k) begin
        key_d[k] = wed_pkg::KEY_MAX;
      end else if (cfg_i.want_maximum) begin
        key_d[k] = val_i[k];
        if (c_ext + t_ext < n_ext) viol = 1'b1;
      end else begin
        key_d[k] = ~val_i[k];
        if (c_ext - t_ext > n_ext) viol = 1'b1;
      end
    end
    cand_d.ok     = win_ctx_i.test && !viol;
    cand_d.idx    = win_ctx_i.idx;
    cand_d.centre = centre;
    cand_d.along  = pos_i[IW'(rad_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= win_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && win_v_i) begin
      cand_q <= cand_d;
      key_q  <= key_d;
    end
  end

  assign v_o    = v_q;
  assign cand_o = cand_q;
  assign key_o  = key_q;

endmodule

// ===== hw/rtl/wed_reduce.sv =====
// ============================================================================
// wed_reduce
// Registered four-to-one minimum tree over the neighbour keys.
// ============================================================================
module wed_reduce #(
  parameter int MaxRadius = wed_pkg::MAX_RADIUS,
  localparam int N = 2 * MaxRadius + 1,
  localparam int L = wed_pkg::tree_levels(N)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            v_i,
  input  wed_pkg::cand_t  cand_i,
  input  wed_pkg::val_t   key_i [N],
  output logic            free_o,
  input  logic            adv_i,
  output logic            v_o,
  output wed_pkg::cand_t  cand_o,
  output wed_pkg::val_t   key_o
);

  logic           v_q    [L];
  wed_pkg::cand_t cand_q [L];
  wed_pkg::val_t  lvl_q  [L][N];

  logic           ld     [L];
  logic           v_in   [L];
  wed_pkg::cand_t cand_in[L];
  wed_pkg::val_t  lvl_in [L][N];
  wed_pkg::val_t  nxt    [L][N];

  always_comb begin
    logic nxt_ld;
    nxt_ld = adv_i;
    for (int j = L - 1; j >= 0; j--) begin
      ld[j]  = !v_q[j] || nxt_ld;
      nxt_ld = ld[j];
    end
  end

  always_comb begin
    v_in[0]    = v_i;
    cand_in[0] = cand_i;
    lvl_in[0]  = key_i;
    for (int j = 1; j < L; j++) begin
      v_in[j]    = v_q[j-1];
      cand_in[j] = cand_q[j-1];
      lvl_in[j]  = lvl_q[j-1];
    end
  end

  always_comb begin
    int            cin;
    int            cout;
    int            src;
    wed_pkg::val_t quad [4];
    for (int j = 0; j < L; j++) begin
      cin  = wed_pkg::level_count(N, j);
      cout = wed_pkg::level_count(N, j + 1);
      for (int i = 0; i < N; i++) begin
        for (int q = 0; q < 4; q++) begin
          src     = (4 * i + q < cin) ? 4 * i + q : 0;
          quad[q] = (4 * i + q < cin) ? lvl_in[j][src] : wed_pkg::KEY_MAX;
        end
        nxt[j][i] = (i < cout) ? wed_pkg::key_min4(quad[0], quad[1], quad[2], quad[3])
                               : wed_pkg::KEY_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < L; j++) begin
        v_q[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < L; j++) begin
        if (ld[j]) v_q[j] <= v_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      if (ld[j] && v_in[j]) begin
        cand_q[j] <= cand_in[j];
        lvl_q[j]  <= nxt[j];
      end
    end
  end

  assign free_o = ld[0];
  assign v_o    = v_q[L-1];
  assign cand_o = cand_q[L-1];
  assign key_o  = lvl_q[L-1][0];

  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[L-1] && !adv_i) |=> (v_q[L-1] && $stable(lvl_q[L-1][0])))
    else $error("tree output dropped while the next stage was busy");

endmodule

// ===== hw/rtl/windowed_extremum_detector_unit.sv =====
// ============================================================================
// windowed_extremum_detector_unit
// Local maximum or minimum detector with prominence over a sliding window.
// ============================================================================
// One sample is accepted every cycle while out_stall_i stays low. A sample
// passes through the window shift register, a test stage that picks the
// centre and checks the tie tolerance against every neighbour, a registered
// four-to-one minimum tree (three levels at the default maximum radius, in
// general enough levels to reduce 2*MaxRadius+1 keys to one) and the result
// register. The window holds the last 2*MaxRadius+1 samples in shift
// registers and needs no clearing pass: a centre is only tested once the
// current profile has filled the window. Samples that produce no result
// leave no gap at the output.
module windowed_extremum_detector_unit #(
  parameter int MaxRadius  = wed_pkg::MAX_RADIUS,
  parameter int MaxSamples = wed_pkg::MAX_SAMPLES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wed_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wed_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [wed_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wed_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int N  = 2 * MaxRadius + 1;
  localparam int RW = $clog2(MaxRadius + 1);
  localparam int W1 = wed_pkg::VAL_W + 1;

  wed_pkg::cfg_t     cfg_q;
  logic [RW-1:0]     rad;

  logic              win_v;
  wed_pkg::win_ctx_t win_ctx;
  wed_pkg::val_t     win_val [N];
  wed_pkg::val_t     win_pos [N];

  logic              tst_free;
  logic              tst_v;
  wed_pkg::cand_t    tst_cand;
  wed_pkg::val_t     tst_key [N];

  logic              red_free;
  logic              red_v;
  wed_pkg::cand_t    red_cand;
  wed_pkg::val_t     red_key;

  logic              out_v_q;
  wed_pkg::out_t     out_q;
  logic              out_adv;
  logic              hit;
  logic signed [W1-1:0] prom;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wed_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (wed_pkg::cfg_reg_e'(cfg_index_i))
        wed_pkg::CFG_WINDOW_RADIUS: begin
          cfg_q.window_radius <= cfg_wdata_i[wed_pkg::RAD_W-1:0];
        end
        wed_pkg::CFG_MIN_PROMINENCE: begin
          cfg_q.min_prominence <= cfg_wdata_i[wed_pkg::PROM_W-1:0];
        end
        wed_pkg::CFG_WANT_MAXIMUM: begin
          cfg_q.want_maximum <= cfg_wdata_i[0];
        end
        wed_pkg::CFG_TIE_TOLERANCE: begin
          cfg_q.tie_tolerance <= cfg_wdata_i[wed_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A radius of zero acts as one, and anything above MaxRadius is cut
  // back to the largest radius the window can hold.
  always_comb begin
    if (cfg_q.window_radius == '0) begin
      rad = RW'(1);
    end else if (int'(cfg_q.window_radius) > MaxRadius) begin
      rad = RW'(MaxRadius);
    end else begin
      rad = RW'(cfg_q.window_radius);
    end
  end

  wed_window #(
    .MaxRadius  (MaxRadius),
    .MaxSamples (MaxSamples)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .rad_i      (rad),
    .adv_i      (tst_free),
    .win_v_o    (win_v),
    .ctx_o      (win_ctx),
    .val_o      (win_val),
    .pos_o      (win_pos)
  );

  wed_test #(
    .MaxRadius (MaxRadius)
  ) u_test (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .rad_i     (rad),
    .win_v_i   (win_v),
    .win_ctx_i (win_ctx),
    .val_i     (win_val),
    .pos_i     (win_pos),
    .free_o    (tst_free),
    .adv_i     (red_free),
    .v_o       (tst_v),
    .cand_o    (tst_cand),
    .key_o     (tst_key)
  );

  wed_reduce #(
    .MaxRadius (MaxRadius)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (tst_v),
    .cand_i (tst_cand),
    .key_i  (tst_key),
    .free_o (red_free),
    .adv_i  (out_adv),
    .v_o    (red_v),
    .cand_o (red_cand),
    .key_o  (red_key)
  );

  // The tree key is the neighbour extreme itself in maximum mode and its
  // inverse in minimum mode.
  always_comb begin
    wed_pkg::val_t        ext;
    logic signed [W1-1:0] c_ext;
    logic signed [W1-1:0] e_ext;
    ext   = cfg_q.want_maximum ? red_key : ~red_key;
    c_ext = {red_cand.centre[wed_pkg::VAL_W-1], red_cand.centre};
    e_ext = {ext[wed_pkg::VAL_W-1], ext};
    prom  = cfg_q.want_maximum ? (c_ext - e_ext) : (e_ext - c_ext);
    hit   = red_cand.ok && (prom > 0) &&
            (prom >= $signed({1'b0, cfg_q.min_prominence}));
  end

  assign out_adv = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= red_v && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && red_v && hit) begin
      out_q.center_index    <= red_cand.idx;
      out_q.center_along    <= red_cand.along;
      out_q.peak_prominence <= prom[wed_pkg::PROM_W-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_prom_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.peak_prominence != '0))
    else $error("result reported with zero prominence");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled although the result side is free");

endmodule

// ===== tb/sv/wed_peak_checker.sv =====
// ============================================================================
// wed_peak_checker
// Watches the sample and result channels of the windowed extremum detector,
// keeps its own copy of the sample window, the profile index and the register
// settings, and works out which centre each accepted sample reports. Results
// leaving the block are compared with the oldest outstanding prediction.
// ============================================================================
module wed_peak_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  wed_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  wed_pkg::out_t                  out_data_i,
  input  logic                           cfg_we_i,
  input  logic [wed_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wed_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 2 * wed_pkg::MAX_RADIUS + 1;

  wed_pkg::cfg_t settings;
  wed_pkg::val_t heights   [WIN_DEPTH];
  wed_pkg::val_t positions [WIN_DEPTH];
  int unsigned   profile_index;
  wed_pkg::out_t expected_peaks [$];
  wed_pkg::out_t oldest_peak;

  // Shifts one sample into the window and queues the centre it reports, if any.
  task automatic predict_peak(input wed_pkg::in_t s);
    int unsigned   r;
    int unsigned   k;
    longint        centre;
    longint        nb;
    longint        lo;
    longint        hi;
    longint        prom;
    longint        tol;
    bit            ok;
    wed_pkg::out_t peak;
    r = settings.window_radius;
    if (r < 1) r = 1;
    if (r > wed_pkg::MAX_RADIUS) r = wed_pkg::MAX_RADIUS;
    for (k = WIN_DEPTH - 1; k > 0; k--) begin
      heights[k]   = heights[k-1];
      positions[k] = positions[k-1];
    end
    heights[0]   = s.sample_value;
    positions[0] = s.along_pos;

    if (profile_index >= 2 * r) begin
      centre = heights[r];
      tol    = settings.tie_tolerance;
      lo     = longint'(1) << 40;
      hi     = -(longint'(1) << 40);
      ok     = 1'b1;
      for (k = 0; k <= 2 * r; k++) begin
        if (k != r) begin
          nb = heights[k];
          if (nb < lo) lo = nb;
          if (nb > hi) hi = nb;
          if (settings.want_maximum ? (centre + tol < nb) : (centre - tol > nb)) ok = 1'b0;
        end
      end
      prom = settings.want_maximum ? centre - lo : hi - centre;
      if (ok && prom > 0 && prom >= longint'(settings.min_prominence)) begin
        peak.center_index    = wed_pkg::IDX_W'(profile_index - r);
        peak.center_along    = positions[r];
        peak.peak_prominence = wed_pkg::PROM_W'(prom);
        expected_peaks.insert(expected_peaks.size(), peak);
      end
    end

    if (s.last_sample) profile_index = 0;
    else if (profile_index < wed_pkg::MAX_SAMPLES - 1) profile_index++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings      = wed_pkg::CFG_RESET;
      heights       = '{default: '0};
      positions     = '{default: '0};
      profile_index = 0;
      expected_peaks.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_peaks.size() == 0) begin
          $display("%0t: unexpected result beat: index %0d along %0d prominence %0d",
                   $time, out_data_i.center_index, out_data_i.center_along,
                   out_data_i.peak_prominence);
          fail_count_o <= fail_count_o + 1;
        end else begin
          oldest_peak = expected_peaks.pop_front();
          if (out_data_i !== oldest_peak) begin
            $display({"%0t: result mismatch: expected index %0d along %0d prominence %0d,",
                      " got index %0d along %0d prominence %0d"},
                     $time, oldest_peak.center_index, oldest_peak.center_along,
                     oldest_peak.peak_prominence, out_data_i.center_index,
                     out_data_i.center_along, out_data_i.peak_prominence);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      if (cfg_we_i) begin
        case (wed_pkg::cfg_reg_e'(cfg_index_i))
          wed_pkg::CFG_WINDOW_RADIUS:
            settings.window_radius  = cfg_wdata_i[wed_pkg::RAD_W-1:0];
          wed_pkg::CFG_MIN_PROMINENCE:
            settings.min_prominence = cfg_wdata_i[wed_pkg::PROM_W-1:0];
          wed_pkg::CFG_WANT_MAXIMUM:
            settings.want_maximum   = cfg_wdata_i[0];
          wed_pkg::CFG_TIE_TOLERANCE:
            settings.tie_tolerance  = cfg_wdata_i[wed_pkg::TOL_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) predict_peak(in_data_i);
      pending_o <= expected_peaks.size();
    end
  end

endmodule

// ===== tb/sv/tb_windowed_extremum_detector_unit.sv =====
// ============================================================================
// tb_windowed_extremum_detector_unit
// Drives profiles of samples into the windowed extremum detector under a
// series of register settings and idling patterns, and gives the verdict
// from the failure count of the peak checker.
// ============================================================================
module tb_windowed_extremum_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 123;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     QUIET_LIMIT  = 2000;
  localparam longint HEIGHT_MAX   = 134217727;
  localparam longint HEIGHT_MIN   = -134217728;

  typedef struct {
    logic [wed_pkg::CFG_DATA_W-1:0] radius_raw;
    logic [wed_pkg::CFG_DATA_W-1:0] min_prom_raw;
    logic [wed_pkg::CFG_DATA_W-1:0] maximum_raw;
    logic [wed_pkg::CFG_DATA_W-1:0] tolerance_raw;
  } setting_t;

  // Some entries carry junk above the register width, which must be dropped.
  setting_t plan [PHASES] = '{
    '{28'd1,         28'd0,         28'd1,         28'd0},
    '{28'd18,        28'hFFF_FFFF,  28'd0,         28'd4095},
    '{28'h000_ABC0,  28'd3277,      28'h000_0002,  28'hABC_D004},
    '{28'hFFF_FFFF,  28'd100,       28'hFFF_FFFF,  28'hFFF_FFFF},
    '{28'd3,         28'd50000,     28'd1,         28'd12},
    '{28'd7,         28'd0,         28'd0,         28'd0},
    '{28'd2,         28'd1,         28'd1,         28'd3},
    '{28'd10,        28'd4096,      28'd0,         28'd64}
  };

  int unsigned gap_mix   [4] = '{0, 58, 0, 27};
  int unsigned stall_mix [4] = '{0, 0, 58, 27};

  logic                           clk_i;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  wed_pkg::in_t                   in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  wed_pkg::out_t                  out_data;
  logic                           cfg_we    = 1'b0;
  wed_pkg::cfg_reg_e              cfg_index = wed_pkg::CFG_WINDOW_RADIUS;
  logic [wed_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  windowed_extremum_detector_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  wed_peak_checker peak_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("windowed_extremum_detector_unit verification failed");
        $finish;
      end
    end
  end

  function automatic longint clamp_height(input longint h);
    if (h > HEIGHT_MAX) return HEIGHT_MAX;
    if (h < HEIGHT_MIN) return HEIGHT_MIN;
    return h;
  endfunction

  function automatic int unsigned radius_in_use(
      input logic [wed_pkg::CFG_DATA_W-1:0] raw);
    int unsigned r;
    r = raw[wed_pkg::RAD_W-1:0];
    if (r < 1) r = 1;
    if (r > wed_pkg::MAX_RADIUS) r = wed_pkg::MAX_RADIUS;
    return r;
  endfunction

  // Leaves the beat on the bus until the block takes it.
  task automatic send_sample(input longint height,
                             input logic [wed_pkg::VAL_W-1:0] along,
                             input bit last);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_value: wed_pkg::VAL_W'(height), along_pos: along,
                  last_sample: last};
    do @(posedge clk_i); while (in_stall);
  endtask

  // Sender pauses until every predicted result is out and the pipe has emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input setting_t s);
    cfg_we    <= 1'b1;
    cfg_index <= wed_pkg::CFG_WINDOW_RADIUS;
    cfg_wdata <= s.radius_raw;
    @(posedge clk_i);
    cfg_index <= wed_pkg::CFG_MIN_PROMINENCE;
    cfg_wdata <= s.min_prom_raw;
    @(posedge clk_i);
    cfg_index <= wed_pkg::CFG_WANT_MAXIMUM;
    cfg_wdata <= s.maximum_raw;
    @(posedge clk_i);
    cfg_index <= wed_pkg::CFG_TIE_TOLERANCE;
    cfg_wdata <= s.tolerance_raw;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_profile(input int len, input bit close);
    int                        shape;
    int                        k;
    int                        period;
    int                        ramp;
    int unsigned               walk;
    longint                    height;
    longint                    base;
    longint                    amp;
    logic [wed_pkg::VAL_W-1:0] along;
    logic [wed_pkg::VAL_W-1:0] pos_step;
    shape    = $urandom_range(0, 7);
    base     = longint'($signed(wed_pkg::VAL_W'($urandom)));
    amp      = longint'($urandom_range(1, 1 << 16)) << $urandom_range(0, 10);
    walk     = $urandom_range(1, 20000);
    period   = $urandom_range(3, 30);
    along    = wed_pkg::VAL_W'($urandom);
    pos_step = wed_pkg::VAL_W'($urandom_range(0, 1 << 14));
    height   = base;
    for (k = 0; k < len; k++) begin
      case (shape)
        0: begin
          height = longint'($signed(wed_pkg::VAL_W'($urandom)));
          along  = wed_pkg::VAL_W'($urandom);
        end
        1, 2: height = clamp_height(height + longint'($urandom_range(0, 2 * walk))
                                    - longint'(walk));
        3, 4: begin
          ramp = k % period;
          if (ramp > period / 2) ramp = period - ramp;
          height = clamp_height(base + amp * ramp + longint'($urandom_range(0, 3)));
        end
        // Ripple around the tie tolerance.
        5: height = clamp_height(base + longint'($urandom_range(0, 8)));
        // Flat stretches give zero prominence; lone spikes break them up.
        6: height = (k % 7 == 3) ? clamp_height(base + amp) : base;
        default: height = (k % 2 == 1) ? HEIGHT_MAX : HEIGHT_MIN;
      endcase
      send_sample(height, along, close && (k == len - 1));
      along = along + pos_step;
    end
  endtask

  initial begin
    int          p;
    int          k;
    int          len;
    int          sent;
    int unsigned r_eff;
    bit          close_final;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: radius 5, maximum mode, tolerance 4.
    gap_pct   = gap_mix[3];
    stall_pct = stall_mix[3];
    // Full-scale peak at the centre of a window-sized profile.
    for (k = 0; k < 11; k++) begin
      send_sample((k == 5) ? HEIGHT_MAX : HEIGHT_MIN,
                  (k == 5) ? wed_pkg::VAL_W'(HEIGHT_MIN) : wed_pkg::VAL_W'(HEIGHT_MAX),
                  k == 10);
    end
    // Profile too short to fill the window.
    for (k = 0; k < 3; k++) send_sample(HEIGHT_MAX, wed_pkg::VAL_W'(k), k == 2);
    // Neighbours exactly at the tolerance above the centre, zero prominence.
    for (k = 0; k < 11; k++) begin
      send_sample((k % 2 == 1 && k != 5) ? 1004 : 1000, wed_pkg::VAL_W'(k * 4096),
                  k == 10);
    end

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      apply_settings(plan[p]);
      gap_pct     = gap_mix[p % 4];
      stall_pct   = stall_mix[p % 4];
      r_eff       = radius_in_use(plan[p].radius_raw);
      // An open profile at the end carries over into the next radius.
      close_final = $urandom_range(0, 1);
      sent        = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 2 * r_eff);
        else len = $urandom_range(2 * r_eff + 1, 2 * r_eff + 40);
        send_profile(len, (sent + len < PHASE_ITEMS) || close_final);
        sent += len;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("windowed_extremum_detector_unit verification clean");
    end else begin
      $display("windowed_extremum_detector_unit verification failed");
    end
    $finish;
  end

endmodule
